// File: design/qrm_pkg.sv
`timescale 1ns / 1ps
package qrm_pkg;

  localparam int CW = 16;
  localparam int FRAC_W = CW - 1;
  localparam int PROD_W = 2 * CW;
  localparam int DEN_W = 2 * CW + 1;
  localparam int NUM_W = 2 * CW + 2;
  localparam int QW = CW + 1;
  localparam int NLANE = 9;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [NLANE-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]            den;
  } qrm_item_t;

endpackage

// File: design/qrm_front.sv
`timescale 1ns / 1ps
module qrm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [qrm_pkg::CW-1:0]     quat_x,
  input  logic signed [qrm_pkg::CW-1:0]     quat_y,
  input  logic signed [qrm_pkg::CW-1:0]     quat_z,
  input  logic signed [qrm_pkg::CW-1:0]     quat_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output qrm_pkg::qrm_item_t                out_item
);
  import qrm_pkg::*;

  function automatic logic signed [NUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return NUM_W'(p);
  endfunction

  logic en;
  logic a_vld;
  logic b_vld;
  logic signed [PROD_W-1:0] pxx, pyy, pzz, pww, pxy, pzw, pxz, pyw, pyz, pxw;
  logic signed [NUM_W-1:0] exx, eyy, ezz, eww, exy, ezw, exz, eyw, eyz, exw, n2;
  qrm_item_t item_next;
  qrm_item_t item;

  assign en = !b_vld || out_ready;
  assign in_ready = en;
  assign out_valid = b_vld;
  assign out_item = item;

  always_comb begin
    exx = ext(pxx);
    eyy = ext(pyy);
    ezz = ext(pzz);
    eww = ext(pww);
    exy = ext(pxy);
    ezw = ext(pzw);
    exz = ext(pxz);
    eyw = ext(pyw);
    eyz = ext(pyz);
    exw = ext(pxw);
    n2 = exx + eyy + ezz + eww;
    item_next.den = n2[DEN_W-1:0];
    item_next.num[0] = exx - eyy - ezz + eww;
    item_next.num[1] = (exy - ezw) <<< 1;
    item_next.num[2] = (exz + eyw) <<< 1;
    item_next.num[3] = (exy + ezw) <<< 1;
    item_next.num[4] = eyy - exx - ezz + eww;
    item_next.num[5] = (eyz - exw) <<< 1;
    item_next.num[6] = (exz - eyw) <<< 1;
    item_next.num[7] = (eyz + exw) <<< 1;
    item_next.num[8] = ezz - exx - eyy + eww;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= quat_x * quat_x;
      pyy <= quat_y * quat_y;
      pzz <= quat_z * quat_z;
      pww <= quat_w * quat_w;
      pxy <= quat_x * quat_y;
      pzw <= quat_z * quat_w;
      pxz <= quat_x * quat_z;
      pyw <= quat_y * quat_w;
      pyz <= quat_y * quat_z;
      pxw <= quat_x * quat_w;
      item <= item_next;
    end
  end

endmodule

// File: design/qrm_queue.sv
`timescale 1ns / 1ps
module qrm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  qrm_pkg::qrm_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output qrm_pkg::qrm_item_t pop_item
);
  import qrm_pkg::*;

  qrm_item_t entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic push;
  logic pop;

  assign push_ready = cnt != QCNT_W'(QDEPTH);
  assign pop_valid = cnt != '0;
  assign pop_item = entry[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

// File: design/qrm_back.sv
`timescale 1ns / 1ps
module qrm_back (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  qrm_pkg::qrm_item_t                        in_item,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [qrm_pkg::NLANE-1:0][qrm_pkg::CW-1:0] m,
  output logic                                      zero_norm
);
  import qrm_pkg::*;

  localparam int NST = QW;

  logic en;
  logic                         vld [NST+1];
  logic [NLANE-1:0][NUM_W-1:0]  rem [NST+1];
  logic [NLANE-1:0][QW-1:0]     q   [NST+1];
  logic [NLANE-1:0]             neg [NST+1];
  logic [DEN_W-1:0]             den [NST+1];
  logic [NLANE-1:0][NUM_W-1:0]  rem_next [NST+1];
  logic [NLANE-1:0][QW-1:0]     q_next   [NST+1];
  logic [NLANE-1:0]             neg_next;
  logic [NLANE-1:0][CW-1:0]     m_next;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    logic [NUM_W-1:0] sh;
    logic ge;
    logic [QW:0] mag;
    for (int j = 0; j < NLANE; j++) begin
      neg_next[j] = in_item.num[j][NUM_W-1];
      rem_next[0][j] = neg_next[j] ? NUM_W'(-in_item.num[j]) : in_item.num[j];
      q_next[0][j] = '0;
    end
    for (int s = 1; s <= NST; s++) begin
      for (int j = 0; j < NLANE; j++) begin
        sh = (s == 1) ? rem[s-1][j] : {rem[s-1][j][NUM_W-2:0], 1'b0};
        ge = sh >= NUM_W'(den[s-1]);
        rem_next[s][j] = ge ? sh - NUM_W'(den[s-1]) : sh;
        q_next[s][j] = {q[s-1][j][QW-2:0], ge};
      end
    end
    for (int j = 0; j < NLANE; j++) begin
      mag = ((QW+1)'(q[NST][j]) + 1'b1) >> 1;
      if (den[NST] == '0) begin
        m_next[j] = '0;
      end else if (!neg[NST][j]) begin
        m_next[j] = (mag > (QW+1)'((1 << FRAC_W) - 1)) ? CW'((1 << FRAC_W) - 1)
                                                        : mag[CW-1:0];
      end else begin
        if (mag > (QW+1)'(1 << FRAC_W)) begin
          mag = (QW+1)'(1 << FRAC_W);
        end
        m_next[j] = CW'(-mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NST; s++) begin
        vld[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s <= NST; s++) begin
        vld[s] <= vld[s-1];
      end
      out_valid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= rem_next[0];
      q[0] <= q_next[0];
      neg[0] <= neg_next;
      den[0] <= in_item.den;
      for (int s = 1; s <= NST; s++) begin
        rem[s] <= rem_next[s];
        q[s] <= q_next[s];
        neg[s] <= neg[s-1];
        den[s] <= den[s-1];
      end
      m <= m_next;
      zero_norm <= den[NST] == '0;
    end
  end

`ifndef ASSERT_OFF
  a_zero_gives_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_norm |-> m == '0)
    else $error("zero norm with nonzero matrix");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !vld[0])
    else $error("valid after reset");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted item lost at divider entry");
`endif

endmodule

// File: design/quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Pipeline, from input accept to output valid: 2 multiply/sum stages, queue,
// 1 sign stage, 17 divider steps (pipelined restoring lanes), output register.
// Throughput: one item per cycle unless out_ready stalls; set by the divider lanes.
// Reset: synchronous, active high; clears all valid flags and the queue.
module quaternion_to_rotation_matrix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [qrm_pkg::CW-1:0] quat_x,
  input  logic signed [qrm_pkg::CW-1:0] quat_y,
  input  logic signed [qrm_pkg::CW-1:0] quat_z,
  input  logic signed [qrm_pkg::CW-1:0] quat_w,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [qrm_pkg::CW-1:0] m00,
  output logic signed [qrm_pkg::CW-1:0] m01,
  output logic signed [qrm_pkg::CW-1:0] m02,
  output logic signed [qrm_pkg::CW-1:0] m10,
  output logic signed [qrm_pkg::CW-1:0] m11,
  output logic signed [qrm_pkg::CW-1:0] m12,
  output logic signed [qrm_pkg::CW-1:0] m20,
  output logic signed [qrm_pkg::CW-1:0] m21,
  output logic signed [qrm_pkg::CW-1:0] m22,
  output logic                          zero_norm
);
  import qrm_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  qrm_item_t f_item, b_item;
  logic [NLANE-1:0][CW-1:0] m;

  qrm_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  qrm_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_item(b_item)
  );

  qrm_back u_back (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .m(m), .zero_norm(zero_norm)
  );

  assign m00 = m[0];
  assign m01 = m[1];
  assign m02 = m[2];
  assign m10 = m[3];
  assign m11 = m[4];
  assign m12 = m[5];
  assign m20 = m[6];
  assign m21 = m[7];
  assign m22 = m[8];

endmodule
